FILE: design/bsa_pkg.sv
package bsa_pkg;

    // configuration port layout
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int LEN_REG_BITS  = 7;
    localparam int ROWS_REG_BITS = 5;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_LEN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_BLOCKS = 2'd1;

    // register reset values
    localparam logic [LEN_REG_BITS-1:0]  LEN_RESET  = 7'd64;
    localparam logic [ROWS_REG_BITS-1:0] ROWS_RESET = 5'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV_A,
        ST_DIV_B,
        ST_PUSH
    } bsa_state_t;

endpackage

FILE: design/bsa_ram.sv
module bsa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bsa_div.sv
module bsa_div #(
    parameter int SUM_BITS = 28,
    parameter int ROWS_MAX = 16,
    parameter int Q_BITS   = 24,
    parameter int RB       = $clog2(ROWS_MAX + 1)
) (
    input  logic                       aclk,
    input  logic signed [SUM_BITS-1:0] sum,
    input  logic [RB-1:0]              rows,
    output logic                       neg,
    output logic [Q_BITS-1:0]          q_mag
);

    localparam int RW = SUM_BITS + 1;
    localparam int PW = SUM_BITS + RW;

    // reciprocal table, floor(2^SUM_BITS / d)
    logic [RW-1:0] recip_tab [ROWS_MAX+1];

    for (genvar g = 0; g <= ROWS_MAX; g++) begin : g_rcp
        localparam int unsigned Div = (g == 0) ? 1 : g;
        if (g == 0) begin : g_zero
            assign recip_tab[g] = '0;
        end else begin : g_val
            assign recip_tab[g] = RW'((64'd1 << SUM_BITS) / Div);
        end
    end

    logic [SUM_BITS-1:0] mag;
    logic [PW-1:0]       prod_reg;
    logic [SUM_BITS-1:0] mag_reg;
    logic                neg_a_reg;
    logic [SUM_BITS-1:0] q0;
    logic [SUM_BITS-1:0] back;
    logic [SUM_BITS-1:0] rem;
    logic [SUM_BITS-1:0] q_next;
    logic [Q_BITS-1:0]   q_mag_reg;
    logic                neg_reg;

    // stage A: magnitude times reciprocal
    always_comb begin
        mag = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= PW'(mag) * PW'(recip_tab[rows]);
        mag_reg   <= mag;
        neg_a_reg <= sum[SUM_BITS-1];
    end

    // stage B: estimate is exact or one short, fix with one compare
    always_comb begin
        q0   = prod_reg[SUM_BITS +: SUM_BITS];
        back = SUM_BITS'(q0 * SUM_BITS'(rows));
        rem  = mag_reg - back;
        if (rem >= SUM_BITS'(rows)) begin
            q_next = q0 + SUM_BITS'(1);
        end else begin
            q_next = q0;
        end
    end

    always_ff @(posedge aclk) begin
        q_mag_reg <= Q_BITS'(q_next);
        neg_reg   <= neg_a_reg;
    end

    assign q_mag = q_mag_reg;
    assign neg   = neg_reg;

endmodule

FILE: design/block_synchronous_averager.sv
// Block synchronous averager: mean over the last num_blocks blocks per column.
// An accepted sample beat passes the store read-modify-write, the two-stage reciprocal
// divider and the output load before its result reaches the master side. The block takes
// one sample at a time; a result waiting on the master side does not stop the next sample
// from being accepted. Reset and any register write clear pointers and fill flags;
// memories are not swept, entries not yet written since the clear read as zero.
module block_synchronous_averager
    import bsa_pkg::*;
#(
    parameter int BLOCK_MAX   = 64,
    parameter int ROWS_MAX    = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // slave stream: tdata = sample[SAMPLE_BITS-1:0], zero padded
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // master stream: tdata = mean[SAMPLE_BITS-1:0], zero padded
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SUM_BITS  = SAMPLE_BITS + ((ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 0);
    localparam int COL_BITS  = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
    localparam int ROW_BITS  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int LB        = $clog2(BLOCK_MAX + 1);
    localparam int RB        = $clog2(ROWS_MAX + 1);
    localparam int ST_DEPTH  = ROWS_MAX * BLOCK_MAX;
    localparam int ST_AW     = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

    bsa_state_t state_reg, state_next;

    logic [LEN_REG_BITS-1:0]  block_len_reg;
    logic [ROWS_REG_BITS-1:0] num_blocks_reg;
    logic [COL_BITS-1:0]      col_reg;
    logic [ROW_BITS-1:0]      row_reg;
    logic                     store_full_reg;
    logic                     sums_live_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [SAMPLE_BITS-1:0]   mean_reg;
    logic                     m_tvalid_reg;

    logic [LB-1:0]            len_eff;
    logic [RB-1:0]            rows_eff;
    logic [ST_AW-1:0]         st_addr;
    logic [SAMPLE_BITS-1:0]   st_rdata;
    logic [SUM_BITS-1:0]      cs_rdata;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic signed [SUM_BITS-1:0]    old_sum;
    logic signed [SUM_BITS-1:0]    new_sum;
    logic                     cfg_wr;
    logic                     rmw_we;
    logic                     out_free;
    logic                     out_load;
    logic                     div_neg;
    logic [SAMPLE_BITS-1:0]   div_q;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready &&
                       (cfg_index == REG_BLOCK_LEN || cfg_index == REG_NUM_BLOCKS);

    // effective block length and row count, out-of-range values clamped
    always_comb begin
        if (block_len_reg == '0) begin
            len_eff = LB'(1);
        end else if (32'(block_len_reg) > BLOCK_MAX) begin
            len_eff = LB'(BLOCK_MAX);
        end else begin
            len_eff = LB'(block_len_reg);
        end
        if (num_blocks_reg == '0) begin
            rows_eff = RB'(1);
        end else if (32'(num_blocks_reg) > ROWS_MAX) begin
            rows_eff = RB'(ROWS_MAX);
        end else begin
            rows_eff = RB'(num_blocks_reg);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_len_reg  <= LEN_RESET;
            num_blocks_reg <= ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_BLOCK_LEN) begin
                block_len_reg <= cfg_data;
            end else if (cfg_index == REG_NUM_BLOCKS) begin
                num_blocks_reg <= cfg_data[ROWS_REG_BITS-1:0];
            end
        end
    end

    // memories, always read at the current pointers
    assign st_addr = ST_AW'(32'(row_reg) * BLOCK_MAX + 32'(col_reg));

    bsa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (ST_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (rmw_we),
        .waddr (st_addr),
        .wdata (sample_reg),
        .raddr (st_addr),
        .rdata (st_rdata)
    );

    bsa_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (BLOCK_MAX)
    ) u_sums (
        .aclk  (aclk),
        .we    (rmw_we),
        .waddr (col_reg),
        .wdata (new_sum),
        .raddr (col_reg),
        .rdata (cs_rdata)
    );

    // running column sum update; unwritten entries read as zero
    always_comb begin
        old_sample = store_full_reg ? signed'(st_rdata) : '0;
        old_sum    = sums_live_reg ? signed'(cs_rdata) : '0;
        new_sum    = old_sum + SUM_BITS'(sample_reg) - SUM_BITS'(old_sample);
    end

    // sample capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rmw_we) begin
            sum_reg <= new_sum;
        end
    end

    // pointers and fill flags
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            col_reg        <= '0;
            row_reg        <= '0;
            store_full_reg <= 1'b0;
            sums_live_reg  <= 1'b0;
        end else if (rmw_we) begin
            if (32'(col_reg) + 32'd1 >= 32'(len_eff)) begin
                col_reg       <= '0;
                sums_live_reg <= 1'b1;
                if (32'(row_reg) + 32'd1 >= 32'(rows_eff)) begin
                    row_reg        <= '0;
                    store_full_reg <= 1'b1;
                end else begin
                    row_reg <= row_reg + ROW_BITS'(1);
                end
            end else begin
                col_reg <= col_reg + COL_BITS'(1);
            end
        end
    end

    // divide by the row count
    bsa_div #(
        .SUM_BITS (SUM_BITS),
        .ROWS_MAX (ROWS_MAX),
        .Q_BITS   (SAMPLE_BITS)
    ) u_div (
        .aclk  (aclk),
        .sum   (sum_reg),
        .rows  (rows_eff),
        .neg   (div_neg),
        .q_mag (div_q)
    );

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid && s_tready) state_next = ST_RMW;
            ST_RMW:   state_next = ST_DIV_A;
            ST_DIV_A: state_next = ST_DIV_B;
            ST_DIV_B: state_next = ST_PUSH;
            ST_PUSH:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer: outputs
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        s_tready = 1'b0;
        rmw_we   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = !cfg_valid;
            ST_RMW:   rmw_we   = 1'b1;
            ST_DIV_A: ;
            ST_DIV_B: ;
            ST_PUSH:  out_load = out_free;
            default:  ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            mean_reg <= div_neg ? (SAMPLE_BITS'(0) - div_q) : div_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(mean_reg);

endmodule

FILE: tb/block_synchronous_averager_tb.sv
module block_synchronous_averager_tb;
    import bsa_pkg::*;

    localparam int BLOCK_MAX   = 64;
    localparam int ROWS_MAX    = 16;
    localparam int SAMPLE_BITS = 24;
    localparam int TDATA_W     = 24;
    localparam int IDLE_LIMIT  = 5000;
    localparam int NUM_PHASES  = 12;

    // indexes past the register list: a write must leave everything untouched
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [TDATA_W-1:0]       s_tdata = '0;     // [23:0] sample
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [TDATA_W-1:0]       m_tdata;          // [23:0] mean
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // ring of past blocks, running column sums and the expected means they give
    class column_mean_tracker;
        int store [ROWS_MAX][BLOCK_MAX];
        int sums [BLOCK_MAX];
        int row;
        int col;
        logic [LEN_REG_BITS-1:0]  len_reg;
        logic [ROWS_REG_BITS-1:0] rows_reg;
        logic [SAMPLE_BITS-1:0]   expected_means [$];
        int errors;
        int checked;

        function new();
            len_reg  = LEN_RESET;
            rows_reg = ROWS_RESET;
            errors   = 0;
            checked  = 0;
            clear();
        endfunction

        function void clear();
            foreach (store[r, c]) store[r][c] = 0;
            foreach (sums[c]) sums[c] = 0;
            row = 0;
            col = 0;
        endfunction

        function int eff_len();
            if (len_reg == 0) return 1;
            if (len_reg > BLOCK_MAX) return BLOCK_MAX;
            return int'(len_reg);
        endfunction

        function int eff_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > ROWS_MAX) return ROWS_MAX;
            return int'(rows_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx == REG_BLOCK_LEN) begin
                len_reg = val[LEN_REG_BITS-1:0];
                clear();
            end else if (idx == REG_NUM_BLOCKS) begin
                rows_reg = val[ROWS_REG_BITS-1:0];
                clear();
            end
        endfunction

        // replace the oldest sample of this column and predict its mean
        function void note_sample(logic [SAMPLE_BITS-1:0] raw);
            int len;
            int rows;
            int s;
            int mean;
            len  = eff_len();
            rows = eff_rows();
            s    = $signed(raw);
            if (col >= len) col = 0;
            if (row >= rows) row = 0;
            sums[col] += s - store[row][col];
            store[row][col] = s;
            mean = sums[col] / rows;
            expected_means.push_back(mean[SAMPLE_BITS-1:0]);
            col++;
            if (col >= len) begin
                col = 0;
                row++;
                if (row >= rows) row = 0;
            end
        endfunction

        function void check_mean(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] want;
            if (expected_means.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat %0d with no sample waiting: got %0d",
                             checked, $signed(got));
            end else begin
                want = expected_means.pop_front();
                if (want !== got) begin
                    errors++;
                    if (errors <= 10)
                        $display("mean mismatch on beat %0d: expected %0d, got %0d",
                                 checked, $signed(want), $signed(got));
                end
            end
            checked++;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction
    endclass

    column_mean_tracker tracker = new();

    int  idle_cycles = 0;
    int  samples_in = 0;
    int  reg_writes = 0;
    bit  no_stall = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    block_synchronous_averager #(
        .BLOCK_MAX  (BLOCK_MAX),
        .ROWS_MAX   (ROWS_MAX),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom());
        case ($urandom_range(0, 19))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = '0;
            3: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // monitor both streams, watchdog on handshake activity
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_sample(s_tdata[SAMPLE_BITS-1:0]);
                samples_in++;
            end
            if (m_tvalid && m_tready)
                tracker.check_mean(m_tdata[SAMPLE_BITS-1:0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no beat for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, tracker.pending());
                $display("block_synchronous_averager test failed");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            if (no_stall) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
        end
    end

    // one sample beat; tvalid stays high across back-to-back beats
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
        int gap;
        gap = no_stall ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(v);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait for every predicted mean
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, val);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int p;
        int i;
        int count;
        logic [CFG_DATA_BITS-1:0] len_val;
        logic [CFG_DATA_BITS-1:0] nb_val;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, field extremes and alternating bits
        send_sample(24'h000000);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'hFFFFFF);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);

        // directed: one-sample blocks, deepest ring, warm-up then full negative sum
        write_reg(REG_BLOCK_LEN, 7'd1);
        write_reg(REG_NUM_BLOCKS, 7'd16);
        for (i = 0; i < 16; i++) send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        // random phases, each but phase 4 under its own setting
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin len_val = 7'd64;  nb_val = 7'd16;  end
                1: begin len_val = 7'd0;   nb_val = 7'd0;   end
                2: begin len_val = 7'd127; nb_val = 7'd31;  end
                3: begin len_val = 7'd65;  nb_val = 7'd17;  end
                default: begin
                    len_val = CFG_DATA_BITS'(($urandom_range(0, 9) < 7)
                                             ? $urandom_range(1, 8)
                                             : $urandom_range(0, 127));
                    nb_val  = CFG_DATA_BITS'($urandom_range(0, 127));
                end
            endcase
            no_stall = (p % 4 == 3);
            if (p == 4) begin
                // spare indexes: state of the previous phase carries on
                write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom_range(0, 127)));
                write_reg(REG_SPARE_B, 7'h7F);
            end else begin
                write_reg(REG_BLOCK_LEN, len_val);
                write_reg(REG_NUM_BLOCKS, nb_val);
            end
            count = (tracker.eff_len() > 16) ? 100 : $urandom_range(60, 110);
            for (i = 0; i < count; i++) begin
                if (p == 6 && i == 40) drain();
                send_sample(pick_sample());
            end
        end

        drain();
        repeat (20) @(posedge aclk);

        $display("%0d samples over %0d register writes and %0d phases; %0d means checked",
                 samples_in, reg_writes, NUM_PHASES + 2, tracker.checked);
        $display("settings spanned block lengths 0..127 and block counts 0..31, with stalls");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("block_synchronous_averager test passed");
        end else begin
            $display("%0d mismatches, %0d means never arrived",
                     tracker.errors, tracker.pending());
            $display("block_synchronous_averager test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bsa_pkg.sv
design/bsa_ram.sv
design/bsa_div.sv
design/block_synchronous_averager.sv
tb/block_synchronous_averager_tb.sv
